// File: design/multichannel_pi_with_deadband_top_defines.svh
// Assertion macros used by the multichannel PI controller back end.
`ifndef MULTICHANNEL_PI_WITH_DEADBAND_TOP_DEFINES_SVH
`define MULTICHANNEL_PI_WITH_DEADBAND_TOP_DEFINES_SVH

// Check a property on the rising clock edge, quiet while in reset.
`define MPID_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define MPID_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/mpid_pkg.sv
// Types, constants and codes of the multichannel PI controller.
`default_nettype none

package mpid_pkg;

  localparam int CHANNELS = 5;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CH_W   = 3;
  localparam int VAL_W  = 16;
  localparam int GAIN_W = 24;
  localparam int DT_W   = 16;
  localparam int PCT_W  = 7;
  localparam int TERM_W = 24;
  localparam int DUTY_W = 16;
  localparam int MAG_W  = 15;
  localparam int DIR_W  = 2;
  localparam int Q16    = 16;
  localparam int LIM_W  = PCT_W + Q16;

  localparam int MUL_A_W  = GAIN_W;
  localparam int MUL_B_W  = VAL_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int KD_W     = GAIN_W + DT_W;
  localparam int KD_HALF  = KD_W / 2;
  localparam int PART_W   = KD_HALF + VAL_W;
  localparam int INCF_W   = KD_W + VAL_W;
  localparam int INC_W    = INCF_W - Q16;
  localparam int SUM_W    = INC_W + 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [PCT_W-1:0]  MAX_PERCENT      = 7'd100;
  localparam logic [MAG_W-1:0]  MAG_MAX          = 15'd25600;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = 24'd9830;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET = 24'd39322;
  localparam logic [DT_W-1:0]   TIME_STEP_RESET  = 16'd1311;
  localparam logic [PCT_W-1:0]  DUTY_LIMIT_RESET = 7'd100;
  localparam logic [PCT_W-1:0]  MIN_RUN_RESET    = 7'd40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_TIME_STEP  = 3'd2,
    CFG_DUTY_LIMIT = 3'd3,
    CFG_MIN_RUN    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KIND_STEP  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_BRAKE = 2'd0,
    DIR_FWD   = 2'd1,
    DIR_REV   = 2'd2
  } dir_e;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [DT_W-1:0]   time_step;
    logic [PCT_W-1:0]  duty_limit;
    logic [PCT_W-1:0]  min_run_duty;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [CH_W-1:0]   channel;
    logic              err_neg;
    logic [VAL_W-1:0]  err_mag;
  } job_t;

  typedef struct packed {
    logic [MAG_W-1:0]         magnitude;
    dir_e                     direction;
    logic signed [DUTY_W-1:0] duty;
    logic [CH_W-1:0]          channel_out;
  } result_t;

endpackage

`default_nettype wire

// File: design/mpid_front.sv
// Front end: accepts requests, forms the error and filters bad channels.
`default_nettype none

module mpid_front (
  input  wire logic                              s_tvalid_i,
  output logic                                   s_tready_o,
  input  wire logic [mpid_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  input  wire logic                              s_tuser_i,
  input  wire logic                              q_full_i,
  output logic                                   q_push_o,
  output mpid_pkg::job_t                         q_job_o
);
  import mpid_pkg::*;

  logic [CH_W-1:0]  channel;
  logic [VAL_W-1:0] setpoint;
  logic [VAL_W-1:0] measurement;
  logic [VAL_W:0]   diff;
  logic [VAL_W:0]   diff_neg;
  logic             in_range;
  kind_e            kind;

  assign channel     = s_tdata_i[CH_W-1:0];
  assign setpoint    = s_tdata_i[CH_W+VAL_W-1:CH_W];
  assign measurement = s_tdata_i[CH_W+2*VAL_W-1:CH_W+VAL_W];
  assign kind        = kind_e'(s_tuser_i);

  assign diff     = {1'b0, setpoint} - {1'b0, measurement};
  assign diff_neg = -diff;
  assign in_range = int'(channel) < CHANNELS;

  assign s_tready_o = !q_full_i;
  // drop steps aimed at a channel that does not exist
  assign q_push_o   = s_tvalid_i && !q_full_i && ((kind == KIND_CLEAR) || in_range);

  always_comb begin
    q_job_o.kind    = kind;
    q_job_o.channel = channel;
    q_job_o.err_neg = diff[VAL_W];
    q_job_o.err_mag = diff[VAL_W] ? diff_neg[VAL_W-1:0] : diff[VAL_W-1:0];
  end

endmodule

`default_nettype wire

// File: design/mpid_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none

module mpid_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  mpid_pkg::job_t  job_i,
  output logic            full_o,
  output logic            valid_o,
  input  wire logic       pop_i,
  output mpid_pkg::job_t  job_o
);
  import mpid_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = count_q == QCNT_W'(QDEPTH);
  assign valid_o = count_q != '0;
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// File: design/mpid_back.sv
// Back end: shared multiplier sequencer, integral store and result register.
`default_nettype none

`include "multichannel_pi_with_deadband_top_defines.svh"

module mpid_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  mpid_pkg::cfg_t     cfg_i,
  input  wire logic          q_valid_i,
  input  mpid_pkg::job_t     q_job_i,
  output logic               q_pop_o,
  output logic               m_tvalid_o,
  input  wire logic          m_tready_i,
  output mpid_pkg::result_t  m_result_o
);
  import mpid_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_KD   = 7'b0000010,
    S_LO   = 7'b0000100,
    S_HI   = 7'b0001000,
    S_P    = 7'b0010000,
    S_TERM = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e                   state_q, state_d;
  job_t                     job_q;
  logic [KD_W-1:0]          kd_q;
  logic [PART_W-1:0]        lo_q;
  logic [PART_W-1:0]        hi_q;
  logic [INC_W-1:0]         incmag_q;
  logic [PROD_W-1:0]        pm_q;
  logic signed [TERM_W-1:0] term_new_q;
  logic signed [TERM_W-1:0] term_q [CHANNELS];
  logic                     out_valid_q;
  result_t                  out_q;

  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [PROD_W-1:0]        prod;
  logic [INCF_W-1:0]        inc_full;
  logic [IDX_W-1:0]         idx;
  logic [PCT_W-1:0]         lim_pct;
  logic [LIM_W-1:0]         lim;
  logic [LIM_W-1:0]         run_lvl;
  logic signed [SUM_W-1:0]  lim_s;
  logic signed [SUM_W-1:0]  inc_u;
  logic signed [SUM_W-1:0]  inc_s;
  logic signed [SUM_W-1:0]  term_sum;
  logic signed [SUM_W-1:0]  term_cl;
  logic signed [TERM_W-1:0] term_new;
  logic signed [SUM_W-1:0]  p_u;
  logic signed [SUM_W-1:0]  p_s;
  logic signed [SUM_W-1:0]  d_sum;
  logic signed [SUM_W-1:0]  d_cl;
  logic signed [TERM_W-1:0] d_v;
  logic [TERM_W-1:0]        d_mag;
  logic                     run_ok;
  logic [MAG_W-1:0]         mag;
  result_t                  res;
  logic                     out_load;
  logic                     clear_now;

  assign idx = IDX_W'(job_q.channel);

  // shared multiplier
  always_comb begin
    mul_a = cfg_i.prop_gain;
    mul_b = job_q.err_mag;
    unique case (state_q)
      S_KD: begin
        mul_a = cfg_i.integ_gain;
        mul_b = cfg_i.time_step;
      end
      S_LO:    mul_a = MUL_A_W'(kd_q[KD_HALF-1:0]);
      S_HI:    mul_a = MUL_A_W'(kd_q[KD_W-1:KD_HALF]);
      default: mul_a = cfg_i.prop_gain;
    endcase
  end

  assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign inc_full = {hi_q, {KD_HALF{1'b0}}} + INCF_W'(lo_q);

  // limits
  assign lim_pct = (cfg_i.duty_limit > MAX_PERCENT) ? MAX_PERCENT : cfg_i.duty_limit;
  assign lim     = {lim_pct, {Q16{1'b0}}};
  assign run_lvl = {cfg_i.min_run_duty, {Q16{1'b0}}};
  assign lim_s   = $signed(SUM_W'(lim));

  // integral update
  always_comb begin
    inc_u    = $signed(SUM_W'(incmag_q));
    inc_s    = job_q.err_neg ? -inc_u : inc_u;
    term_sum = SUM_W'(term_q[idx]) + inc_s;
    if (term_sum > lim_s) begin
      term_cl = lim_s;
    end else if (term_sum < -lim_s) begin
      term_cl = -lim_s;
    end else begin
      term_cl = term_sum;
    end
    term_new = TERM_W'(term_cl);
  end

  // duty, deadband and direction
  always_comb begin
    p_u   = $signed(SUM_W'(pm_q));
    p_s   = job_q.err_neg ? -p_u : p_u;
    d_sum = p_s + SUM_W'(term_new_q);
    if (d_sum > lim_s) begin
      d_cl = lim_s;
    end else if (d_sum < -lim_s) begin
      d_cl = -lim_s;
    end else begin
      d_cl = d_sum;
    end
    d_v    = TERM_W'(d_cl);
    d_mag  = d_v[TERM_W-1] ? TERM_W'(-d_v) : TERM_W'(d_v);
    run_ok = d_mag >= TERM_W'(run_lvl);
    mag    = run_ok ? MAG_W'(d_mag >> 8) : '0;
    res.channel_out = job_q.channel;
    res.magnitude   = mag;
    if (mag == '0) begin
      res.direction = DIR_BRAKE;
      res.duty      = '0;
    end else if (d_v[TERM_W-1]) begin
      res.direction = DIR_REV;
      res.duty      = -$signed(DUTY_W'(mag));
    end else begin
      res.direction = DIR_FWD;
      res.duty      = $signed(DUTY_W'(mag));
    end
  end

  assign q_pop_o   = (state_q == S_IDLE) && q_valid_i;
  assign clear_now = q_pop_o && (q_job_i.kind == KIND_CLEAR);
  assign out_load  = (state_q == S_OUT) && (!out_valid_q || m_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_pop_o && q_job_i.kind == KIND_STEP) begin
          state_d = S_KD;
        end
      end
      S_KD:   state_d = S_LO;
      S_LO:   state_d = S_HI;
      S_HI:   state_d = S_P;
      S_P:    state_d = S_TERM;
      S_TERM: state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        term_q[i] <= '0;
      end
    end else if (clear_now) begin
      for (int i = 0; i < CHANNELS; i++) begin
        term_q[i] <= '0;
      end
    end else if (state_q == S_TERM) begin
      term_q[idx] <= term_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
    end
    if (state_q == S_KD) begin
      kd_q <= prod;
    end
    if (state_q == S_LO) begin
      lo_q <= PART_W'(prod);
    end
    if (state_q == S_HI) begin
      hi_q <= PART_W'(prod);
    end
    if (state_q == S_P) begin
      pm_q     <= prod;
      incmag_q <= inc_full[INCF_W-1:Q16];
    end
    if (state_q == S_TERM) begin
      term_new_q <= term_new;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_result_o = out_q;

  `MPID_ASSERT(a_out_wait, (state_q == S_OUT && out_valid_q && !m_tready_i) |=> state_q == S_OUT, "result overwritten while stalled")
  `MPID_ASSERT(a_clear_zero, clear_now |=> term_q[0] == '0, "clear left an integral term")
  `MPID_ASSERT_IMPL(a_brake_zero, m_tvalid_o && out_q.direction == DIR_BRAKE, out_q.duty == '0 && out_q.magnitude == '0, "brake with nonzero duty")
  `MPID_ASSERT_IMPL(a_mag_bound, m_tvalid_o, out_q.magnitude <= MAG_MAX, "magnitude above full scale")

endmodule

`default_nettype wire

// File: design/multichannel_pi_with_deadband_top.sv
// Top level of the multichannel PI controller with anti-windup and deadband.
//
// Each step request (tuser 0) runs one PI update for its channel and returns
// one result; a clear request (tuser 1) zeroes every integral term and returns
// nothing, as does a step for a channel that does not exist. A step passes
// through the back-end states in order: a dispatch state, four passes through
// the single shared 24x16 multiplier (ki*dt, two halves of that times the
// error, kp times the error), the integral update and clamp, and the duty
// saturation and deadband. A clear zeroes the terms when it is dispatched. A
// two-entry queue and an output register let requests be taken while a result
// waits. Configuration is taken at once (cfg_ready_o is always high).
`default_nettype none

module multichannel_pi_with_deadband_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // channel[2:0], setpoint[18:3], measurement[34:19], zero[39:35]
  input  wire logic [mpid_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // command[0]
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // channel_out[2:0], duty[18:3], direction[20:19], magnitude[35:21], zero[39:36]
  output logic [mpid_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [mpid_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [mpid_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import mpid_pkg::*;

  cfg_t    cfg_q;
  logic    q_push;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  job_t    push_job;
  job_t    head_job;
  result_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain    <= PROP_GAIN_RESET;
      cfg_q.integ_gain   <= INTEG_GAIN_RESET;
      cfg_q.time_step    <= TIME_STEP_RESET;
      cfg_q.duty_limit   <= DUTY_LIMIT_RESET;
      cfg_q.min_run_duty <= MIN_RUN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PROP_GAIN:  cfg_q.prop_gain    <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEG_GAIN: cfg_q.integ_gain   <= cfg_data_i[GAIN_W-1:0];
        CFG_TIME_STEP:  cfg_q.time_step    <= cfg_data_i[DT_W-1:0];
        CFG_DUTY_LIMIT: cfg_q.duty_limit   <= cfg_data_i[PCT_W-1:0];
        CFG_MIN_RUN:    cfg_q.min_run_duty <= cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  mpid_front u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  mpid_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .job_o   (head_job)
  );

  mpid_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_job_i    (head_job),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_result_o (result)
  );

  assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

`default_nettype wire

// File: bench/pi_duty_checker.sv
// Checker: predicts PI duty results from observed requests and compares them with the output.
module pi_duty_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  input  wire logic                             s_axis_tready,
  // channel[2:0], setpoint[18:3], measurement[34:19], zero[39:35]
  input  wire logic [mpid_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  wire logic                             s_axis_tuser,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // channel_out[2:0], duty[18:3], direction[20:19], magnitude[35:21], zero[39:36]
  input  wire logic [mpid_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                             cfg_valid_i,
  input  wire logic                             cfg_ready_i,
  input  wire logic [mpid_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [mpid_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                                    pending_o,
  output int                                    fail_count_o
);
  import mpid_pkg::*;

  localparam int RES_W = $bits(result_t);

  logic [GAIN_W-1:0] kp_gain;
  logic [GAIN_W-1:0] ki_gain;
  logic [DT_W-1:0]   dt_step;
  logic [PCT_W-1:0]  lim_pct;
  logic [PCT_W-1:0]  min_pct;
  longint            term_q [CHANNELS];

  result_t duty_queue [$];
  result_t want;
  result_t got;
  logic [OUT_TDATA_W-RES_W-1:0] pad;
  int misses;

  function automatic longint toward_zero(input longint v, input int s);
    if (v < 0) return -((-v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic result_t pi_update(input logic [CH_W-1:0] ch,
                                        input logic [VAL_W-1:0] sp,
                                        input logic [VAL_W-1:0] ms);
    longint err, lim, inc, term, d, run, d256;
    result_t r;
    lim = longint'((lim_pct > MAX_PERCENT) ? MAX_PERCENT : lim_pct) << Q16;
    err = longint'(sp) - longint'(ms);
    inc = toward_zero(longint'(ki_gain) * err * longint'(dt_step), Q16);
    term = clamp_sym(term_q[ch] + inc, lim);
    term_q[ch] = term;
    d = clamp_sym(longint'(kp_gain) * err + term, lim);
    run = longint'(min_pct) << Q16;
    d256 = (d >= run || d <= -run) ? toward_zero(d, 8) : 0;
    r.channel_out = ch;
    r.duty = d256[DUTY_W-1:0];
    if (d256 > 0) begin
      r.direction = DIR_FWD;
      r.magnitude = d256[MAG_W-1:0];
    end else if (d256 < 0) begin
      r.direction = DIR_REV;
      r.magnitude = MAG_W'(-d256);
    end else begin
      r.direction = DIR_BRAKE;
      r.magnitude = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint expv, input longint actv);
    if (expv != actv) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, expv, actv);
      misses++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_gain = PROP_GAIN_RESET;
      ki_gain = INTEG_GAIN_RESET;
      dt_step = TIME_STEP_RESET;
      lim_pct = DUTY_LIMIT_RESET;
      min_pct = MIN_RUN_RESET;
      foreach (term_q[k]) term_q[k] = 0;
      duty_queue.delete();
      misses = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PROP_GAIN:  kp_gain = cfg_data_i[GAIN_W-1:0];
          CFG_INTEG_GAIN: ki_gain = cfg_data_i[GAIN_W-1:0];
          CFG_TIME_STEP:  dt_step = cfg_data_i[DT_W-1:0];
          CFG_DUTY_LIMIT: lim_pct = cfg_data_i[PCT_W-1:0];
          CFG_MIN_RUN:    min_pct = cfg_data_i[PCT_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[RES_W-1:0]);
        pad = m_axis_tdata[OUT_TDATA_W-1:RES_W];
        if (duty_queue.size() == 0) begin
          $display("%0t: result expected none actual %h", $time, m_axis_tdata);
          misses++;
        end else begin
          want = duty_queue.pop_front();
          check_field("channel_out", longint'(want.channel_out), longint'(got.channel_out));
          check_field("duty", longint'(want.duty), longint'(got.duty));
          check_field("direction", longint'(want.direction), longint'(got.direction));
          check_field("magnitude", longint'(want.magnitude), longint'(got.magnitude));
          check_field("padding", 0, longint'(pad));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (kind_e'(s_axis_tuser) == KIND_CLEAR) begin
          foreach (term_q[k]) term_q[k] = 0;
        end else if (s_axis_tdata[CH_W-1:0] < CHANNELS) begin
          duty_queue.push_back(pi_update(s_axis_tdata[CH_W-1:0],
                                         s_axis_tdata[CH_W +: VAL_W],
                                         s_axis_tdata[CH_W+VAL_W +: VAL_W]));
        end
      end
      pending_o <= duty_queue.size();
      fail_count_o <= misses;
    end
  end

endmodule

// File: bench/tb_multichannel_pi_with_deadband_top.sv
// Testbench top: drives requests and settings into the PI controller and reports the verdict.
module tb_multichannel_pi_with_deadband_top;
  import mpid_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 24;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  wire                    s_axis_tready;
  wire                    m_axis_tvalid;
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;
  wire                    cfg_ready_o;
  int                     pending;
  int                     fail_count;

  int       burst_left;
  int       cycles = 0;
  int       rx_count = 0;
  rx_mode_e rx_mode = RX_OPEN;

  multichannel_pi_with_deadband_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pi_duty_checker u_duty_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rx_count++;
    if (rx_count % 256 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 5) == 0);
      default:   m_axis_tready <= (rx_count % 7) < 3;
    endcase
  end

  function automatic int next_burst();
    if ($urandom_range(0, 7) == 0) return $urandom_range(40, 80);
    return $urandom_range(1, 16);
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    if ($urandom_range(0, 3) == 0) return GAIN_W'($urandom);
    return GAIN_W'($urandom_range(0, 24'h020000));
  endfunction

  task automatic push_request(input kind_e kind, input logic [CH_W-1:0] ch,
                              input logic [VAL_W-1:0] sp, input logic [VAL_W-1:0] ms);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'b0, ms, sp, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
      burst_left = next_burst();
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = next_burst();
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                           input logic [DT_W-1:0] dt, input logic [PCT_W-1:0] lim,
                           input logic [PCT_W-1:0] min_run, input int steps);
    int done;
    int delta;
    int ms_val;
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] sp;
    logic [VAL_W-1:0] ms;
    if ($urandom_range(0, 2) == 0)
      write_reg(cfg_idx_e'($urandom_range(CFG_MIN_RUN + 1, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_TIME_STEP, CFG_DATA_W'(dt));
    write_reg(CFG_DUTY_LIMIT, CFG_DATA_W'(lim));
    write_reg(CFG_MIN_RUN, CFG_DATA_W'(min_run));
    done = 0;
    while (done < steps) begin
      case ($urandom_range(0, 3))
        0: begin
          sp = VAL_W'($urandom);
          ms = VAL_W'($urandom);
        end
        1: begin
          sp = VAL_W'($urandom);
          delta = int'($urandom_range(0, 800)) - 400;
          ms_val = int'(sp) - delta;
          if (ms_val < 0) ms_val = 0;
          if (ms_val > 65535) ms_val = 65535;
          ms = VAL_W'(ms_val);
        end
        2: begin
          sp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          ms = $urandom_range(0, 2) == 0 ? 16'($urandom)
                                         : ($urandom_range(0, 1) ? 16'hFFFF : 16'h0);
        end
        default: begin
          sp = VAL_W'($urandom_range(0, 1023));
          ms = VAL_W'($urandom_range(0, 1023));
        end
      endcase
      ch = ($urandom_range(0, 9) == 0) ? CH_W'($urandom_range(CHANNELS, 7))
                                        : CH_W'($urandom_range(0, CHANNELS - 1));
      if ($urandom_range(0, 39) == 0) begin
        push_request(KIND_CLEAR, ch, sp, ms);
      end else begin
        push_request(KIND_STEP, ch, sp, ms);
        if (ch < CHANNELS) done++;
      end
      if ($urandom_range(0, 199) == 0) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    logic [PCT_W-1:0] lim;
    burst_left = 4;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_request(KIND_STEP, 3'd0, 16'd0, 16'd0);
    push_request(KIND_STEP, 3'd0, 16'hFFFF, 16'd0);
    push_request(KIND_STEP, 3'd1, 16'd0, 16'hFFFF);
    push_request(KIND_STEP, 3'd2, 16'd300, 16'd33);
    push_request(KIND_STEP, 3'd2, 16'd33, 16'd300);
    push_request(KIND_STEP, 3'd3, 16'd100, 16'd0);
    push_request(KIND_STEP, 3'd3, 16'd0, 16'd100);
    push_request(KIND_STEP, 3'd4, 16'd40000, 16'd39990);
    push_request(KIND_STEP, 3'd5, 16'hFFFF, 16'd0);
    push_request(KIND_STEP, 3'd6, 16'h5555, 16'hAAAA);
    push_request(KIND_STEP, 3'd7, 16'd0, 16'hFFFF);
    repeat (3) push_request(KIND_STEP, 3'd0, 16'hFFFF, 16'd0);
    push_request(KIND_CLEAR, 3'd7, 16'hFFFF, 16'hFFFF);
    push_request(KIND_STEP, 3'd0, 16'd0, 16'd1);
    push_request(KIND_STEP, 3'd0, 16'd1, 16'd0);
    push_request(KIND_STEP, 3'd1, 16'hFFFF, 16'hFFFF);
    push_request(KIND_STEP, 3'd4, 16'd0, 16'hFFFF);
    wait_idle();

    run_phase('0, '0, '0, '0, '0, 40);
    run_phase(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 7'd127, 7'd127, 40);
    lim = PCT_W'($urandom_range(10, 60));
    run_phase(random_gain(), random_gain(), DT_W'($urandom_range(0, 4000)), lim,
              lim + 7'($urandom_range(1, 40)), 40);
    run_phase(random_gain(), '0, DT_W'($urandom), MAX_PERCENT, '0, 40);
    repeat (6) begin
      lim = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(20, 100));
      run_phase(random_gain(), random_gain(),
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000)),
                lim, 7'($urandom_range(0, lim + 10)), 105);
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/mpid_pkg.sv
design/mpid_front.sv
design/mpid_queue.sv
design/mpid_back.sv
design/multichannel_pi_with_deadband_top.sv
bench/pi_duty_checker.sv
bench/tb_multichannel_pi_with_deadband_top.sv
